// ===== hw/rtl/keyed_ordered_list_insert_remove_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ordered key list core
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef KEYED_ORDERED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH
`define KEYED_ORDERED_LIST_INSERT_REMOVE_CORE_DEFINES_SVH

// condition must hold at every clock edge
`define KOLIR_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define KOLIR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/kolir_pkg.sv =====
// ----------------------------------------------------------------------------
// kolir_pkg
// Shared types, codes and helpers for the ordered key list core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package kolir_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int COUNT_BITS = $clog2(CAPACITY + 1);

   localparam int FIELD_BITS      = 32;
   localparam int REQ_TDATA_BITS  = 64;
   localparam int REQ_TUSER_BITS  = 2;
   localparam int RSP_TDATA_BITS  = 40;
   localparam int STATUS_BITS     = 3;

   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [COUNT_BITS-1:0] count_type;

   typedef enum logic [1:0] {
      KIND_APPEND = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_REMOVE = 2'd2,
      KIND_DUMP   = 2'd3
   } kind_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STS_DONE      = 3'd0,
      STS_NOT_FOUND = 3'd1,
      STS_FULL      = 3'd2,
      STS_ENTRY     = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_COMPARE,
      OP_APPEND,
      OP_INSERT,
      OP_REMOVE,
      OP_ROTATE
   } op_type;

   // broadcast to every cell
   typedef struct packed {
      op_type  op;
      key_type search;
      key_type name;
   } ctl_type;

   // per-cell position flags
   typedef struct packed {
      logic valid;       // holds a live entry
      logic at_count;    // first free slot
      logic at_tail;     // last live entry
      logic past_match;  // a cell nearer the head matched
   } pos_type;

   function automatic key_type to_key(input logic [FIELD_BITS-1:0] value);
      logic [FIELD_BITS+KEY_BITS-1:0] wide;
      wide = {{KEY_BITS{1'b0}}, value};
      return wide[KEY_BITS-1:0];
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_field(input key_type value);
      logic [FIELD_BITS+KEY_BITS-1:0] wide;
      wide = {{FIELD_BITS{1'b0}}, value};
      return wide[FIELD_BITS-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/keyed_ordered_list_insert_remove_core.sv =====
// ----------------------------------------------------------------------------
// keyed_ordered_list_insert_remove_core
// Ordered key list with append, insert-before, remove and dump.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on req_*: kind in req_tuser, name and anchor keys in
//    req_tdata. Results leave on rsp_*: status and entry key in rsp_tdata,
//    rsp_tlast marks the final result of a request.
//  - Append, insert and remove: one result. The match state compares every
//    cell against the search key; the apply state then shifts the row and
//    registers the result, waiting while the output register holds a result
//    not yet taken. A new request is taken only once the core is idle again.
//  - Dump: one result per entry, one per cycle while rsp_tready is high;
//    the row rotates round to the head each step and is back in order after
//    the last entry. An empty list gives a single empty-status result.
//  - A request is taken only when the core is idle; a result still waiting
//    in the output register does not block acceptance.
//  - A stalled receiver holds the output register and stalls apply and dump.
//  - Reset empties the list; stored keys are not cleared, only the count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "keyed_ordered_list_insert_remove_core_defines.svh"

module keyed_ordered_list_insert_remove_core (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_tvalid,
   output      logic                                   req_tready,
   // [31:0] name_key, [63:32] anchor_key
   input  wire logic [kolir_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   // [1:0] kind
   input  wire logic [kolir_pkg::REQ_TUSER_BITS-1:0]   req_tuser,
   output      logic                                   rsp_tvalid,
   input  wire logic                                   rsp_tready,
   // [2:0] status, [34:3] entry_key, [39:35] zero
   output      logic [kolir_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,
   output      logic                                   rsp_tlast
);
   import kolir_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_APPLY,
      ST_DUMP
   } state_type;

   state_type              state_ff, state_in;
   kind_type               kind_ff, kind_in;
   key_type                name_ff, name_in;
   key_type                anchor_ff, anchor_in;
   count_type              count_ff, count_in;
   count_type              dump_idx_ff, dump_idx_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   status_type             rsp_status_ff, rsp_status_in;
   logic [FIELD_BITS-1:0]  rsp_key_ff, rsp_key_in;
   logic                   rsp_last_ff, rsp_last_in;

   ctl_type                ctl;
   key_type                head_key;
   logic                   found;
   logic                   out_free;
   logic                   req_take;
   logic                   full;
   count_type              dump_next;

   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign full       = (count_ff == COUNT_BITS'(CAPACITY));
   assign dump_next  = COUNT_BITS'(dump_idx_ff + 1'b1);

   kolir_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .count    (count_ff),
      .head_key (head_key),
      .found    (found)
   );

   always_comb begin
      state_in      = state_ff;
      kind_in       = kind_ff;
      name_in       = name_ff;
      anchor_in     = anchor_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_key_in    = rsp_key_ff;
      rsp_last_in   = rsp_last_ff;
      ctl.op        = OP_HOLD;
      ctl.search    = (kind_ff == KIND_INSERT) ? anchor_ff : name_ff;
      ctl.name      = name_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in     = kind_type'(req_tuser);
               name_in     = to_key(req_tdata[FIELD_BITS-1:0]);
               anchor_in   = to_key(req_tdata[2*FIELD_BITS-1:FIELD_BITS]);
               dump_idx_in = '0;
               state_in    = (kind_type'(req_tuser) == KIND_DUMP) ? ST_DUMP : ST_MATCH;
            end
         end
         ST_MATCH: begin
            ctl.op   = OP_COMPARE;
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_key_in   = '0;
               rsp_last_in  = 1'b1;
               state_in     = ST_IDLE;
               unique case (kind_ff)
                  KIND_APPEND: begin
                     if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        ctl.op        = OP_APPEND;
                        count_in      = COUNT_BITS'(count_ff + 1'b1);
                        rsp_status_in = STS_DONE;
                     end
                  end
                  KIND_INSERT: begin
                     if (!found) begin
                        rsp_status_in = STS_NOT_FOUND;
                     end else if (full) begin
                        rsp_status_in = STS_FULL;
                     end else begin
                        ctl.op        = OP_INSERT;
                        count_in      = COUNT_BITS'(count_ff + 1'b1);
                        rsp_status_in = STS_DONE;
                     end
                  end
                  KIND_REMOVE: begin
                     if (!found) begin
                        rsp_status_in = STS_NOT_FOUND;
                     end else begin
                        ctl.op        = OP_REMOVE;
                        count_in      = COUNT_BITS'(count_ff - 1'b1);
                        rsp_status_in = STS_DONE;
                     end
                  end
                  default: begin
                     rsp_status_in = STS_EMPTY;
                  end
               endcase
            end
         end
         ST_DUMP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (count_ff == '0) begin
                  rsp_status_in = STS_EMPTY;
                  rsp_key_in    = '0;
                  rsp_last_in   = 1'b1;
                  state_in      = ST_IDLE;
               end else begin
                  // emit the head, rotate the live entries by one
                  ctl.op        = OP_ROTATE;
                  rsp_status_in = STS_ENTRY;
                  rsp_key_in    = to_field(head_key);
                  rsp_last_in   = (dump_next == count_ff);
                  dump_idx_in   = dump_next;
                  if (dump_next == count_ff) state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff       <= kind_in;
      name_ff       <= name_in;
      anchor_ff     <= anchor_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff    <= rsp_key_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_TDATA_BITS - FIELD_BITS - STATUS_BITS){1'b0}},
                        rsp_key_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

   `KOLIR_ASSERT_ALWAYS(a_count_bound, count_ff <= COUNT_BITS'(CAPACITY), "count over capacity")
   `KOLIR_ASSERT_NEXT(a_count_only_in_apply, state_ff != ST_APPLY, $stable(count_ff), "count moved outside apply")
   `KOLIR_ASSERT_ALWAYS(a_dump_index, state_ff != ST_DUMP || count_ff == '0 || dump_idx_ff < count_ff, "dump index past tail")
   `KOLIR_ASSERT_NEXT(a_match_then_apply, state_ff == ST_MATCH, state_ff == ST_APPLY, "compare not followed by apply")

endmodule

`default_nettype wire

// ===== hw/rtl/kolir_cell.sv =====
// ----------------------------------------------------------------------------
// kolir_cell
// One list slot: holds a key, compares it, takes a neighbour's key on shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kolir_cell (
   input  wire logic              clock,
   input  wire kolir_pkg::ctl_type ctl,
   input  wire kolir_pkg::pos_type pos,
   input  wire kolir_pkg::key_type left_key,
   input  wire kolir_pkg::key_type right_key,
   input  wire kolir_pkg::key_type head_key,
   output      kolir_pkg::key_type key_out,
   output      logic              match_out
);
   import kolir_pkg::*;

   key_type key_ff, key_in;
   logic    match_ff, match_in;
   logic    first;

   assign first = match_ff & ~pos.past_match;

   always_comb begin
      key_in   = key_ff;
      match_in = match_ff;
      case (ctl.op)
         OP_COMPARE: match_in = pos.valid & (key_ff == ctl.search);
         OP_APPEND:  if (pos.at_count) key_in = ctl.name;
         OP_INSERT: begin
            if (first) key_in = ctl.name;
            else if (pos.past_match) key_in = left_key;
         end
         OP_REMOVE:  if (pos.past_match | match_ff) key_in = right_key;
         OP_ROTATE:  key_in = pos.at_tail ? head_key : right_key;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      match_ff <= match_in;
   end

   assign key_out   = key_ff;
   assign match_out = match_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/kolir_chain.sv =====
// ----------------------------------------------------------------------------
// kolir_chain
// Row of list cells, neighbour wiring, position decode and first-match prefix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module kolir_chain (
   input  wire logic                clock,
   input  wire kolir_pkg::ctl_type   ctl,
   input  wire kolir_pkg::count_type count,
   output      kolir_pkg::key_type   head_key,
   output      logic                found
);
   import kolir_pkg::*;

   key_type             key_row   [CAPACITY];
   key_type             left_row  [CAPACITY];
   key_type             right_row [CAPACITY];
   pos_type             pos_row   [CAPACITY];
   logic [CAPACITY-1:0] match_row;
   logic [CAPACITY-1:0] upto;     // OR of matches at or nearer the head

   // log-depth prefix OR of the match bits
   always_comb begin
      upto = match_row;
      for (int l = 0; l < IDX_BITS; l++) begin
         upto = upto | (upto << (1 << l));
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         left_row[i]           = (i == 0) ? '0 : key_row[(i == 0) ? 0 : i - 1];
         right_row[i]          = (i == CAPACITY - 1) ? '0
                                 : key_row[(i == CAPACITY - 1) ? i : i + 1];
         pos_row[i].valid      = COUNT_BITS'(i) < count;
         pos_row[i].at_count   = COUNT_BITS'(i) == count;
         pos_row[i].at_tail    = COUNT_BITS'(i + 1) == count;
         pos_row[i].past_match = (i == 0) ? 1'b0 : upto[(i == 0) ? 0 : i - 1];
      end
   end

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      kolir_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .pos       (pos_row[g]),
         .left_key  (left_row[g]),
         .right_key (right_row[g]),
         .head_key  (key_row[0]),
         .key_out   (key_row[g]),
         .match_out (match_row[g])
      );
   end

   assign head_key = key_row[0];
   assign found    = |match_row;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the ordered key list core. Requests go in as
// stream transactions. A scoreboard keeps its own copy of the list and
// predicts every result. Each result transaction is checked field by field
// against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import kolir_pkg::*;

   localparam int RANDOM_ITEMS = 40;
   localparam int HOLD_CYCLES  = 300;     // long receiver hold-off
   localparam int CYCLE_LIMIT  = 400000;  // watchdog, far above the slowest run
   localparam int DRAIN_CYCLES = 20;      // settle time after the last result
   localparam int IDLE_PERCENT = 17;
   localparam int PRINT_LIMIT  = 100;

   // one predicted result transaction
   typedef struct {
      status_type  status;
      logic [31:0] entry_key;
      bit          last;
   } list_result_type;

   // -------------------------------------------------------------------------
   // Scoreboard: its own copy of the list, and the queue of results owed
   // -------------------------------------------------------------------------
   class list_scoreboard;
      key_type         keys[CAPACITY];
      int              count;
      list_result_type owed_results[$];
      int              mismatches;

      function new();
         count      = 0;
         mismatches = 0;
      endfunction

      function int outstanding();
         return owed_results.size();
      endfunction

      // first position holding key, -1 when absent
      function int find_key(key_type key);
         int i;
         for (i = 0; i < count; i++)
            if (keys[i] == key) return i;
         return -1;
      endfunction

      // any live key, or a random one when the list is empty
      function logic [31:0] live_key();
         if (count == 0) return $urandom;
         return 32'(keys[$urandom_range(count - 1)]);
      endfunction

      function void owe(status_type status, key_type key, bit last);
         list_result_type r;
         r.status    = status;
         r.entry_key = 32'(key);
         r.last      = last;
         owed_results = {owed_results, r};
      endfunction

      // update the list for one accepted request and queue its results
      function void apply_request(kind_type kind, logic [31:0] name,
                                  logic [31:0] anchor);
         key_type nk;
         key_type ak;
         int      pos;
         int      i;
         nk = key_type'(name);
         ak = key_type'(anchor);
         case (kind)
            KIND_APPEND: begin
               if (count >= CAPACITY) begin
                  owe(STS_FULL, '0, 1'b1);
               end else begin
                  keys[count] = nk;
                  count++;
                  owe(STS_DONE, '0, 1'b1);
               end
            end
            KIND_INSERT: begin
               pos = find_key(ak);
               // missing anchor wins over a full list
               if (pos < 0) begin
                  owe(STS_NOT_FOUND, '0, 1'b1);
               end else if (count >= CAPACITY) begin
                  owe(STS_FULL, '0, 1'b1);
               end else begin
                  for (i = count; i > pos; i--) keys[i] = keys[i-1];
                  keys[pos] = nk;
                  count++;
                  owe(STS_DONE, '0, 1'b1);
               end
            end
            KIND_REMOVE: begin
               pos = find_key(nk);
               if (pos < 0) begin
                  owe(STS_NOT_FOUND, '0, 1'b1);
               end else begin
                  for (i = pos; i + 1 < count; i++) keys[i] = keys[i+1];
                  count--;
                  owe(STS_DONE, '0, 1'b1);
               end
            end
            default: begin
               if (count == 0) begin
                  owe(STS_EMPTY, '0, 1'b1);
               end else begin
                  for (i = 0; i < count; i++)
                     owe(STS_ENTRY, keys[i], (i + 1 == count));
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         mismatches++;
         if (mismatches <= PRINT_LIMIT)
            $display("%0t ns mismatch: %s", $time, what);
      endtask

      task check_result(logic [RSP_TDATA_BITS-1:0] data, logic last);
         list_result_type        want;
         logic [STATUS_BITS-1:0] got_status;
         logic [31:0]            got_key;
         got_status = data[STATUS_BITS-1:0];
         got_key    = data[STATUS_BITS +: 32];
         if (owed_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result, status %0d key %h last %b",
                                      got_status, got_key, last));
            return;
         end
         want = owed_results.pop_front();
         if (got_status !== want.status)
            report_mismatch($sformatf("status %0d, wanted %s",
                                      got_status, want.status.name()));
         if (got_key !== want.entry_key)
            report_mismatch($sformatf("entry key %h, wanted %h", got_key, want.entry_key));
         if (last !== want.last)
            report_mismatch($sformatf("tlast %b, wanted %b", last, want.last));
         if (data[RSP_TDATA_BITS-1:STATUS_BITS+32] !== '0)
            report_mismatch($sformatf("padding bits not zero: %h", data));
      endtask
   endclass

   // -------------------------------------------------------------------------
   // DUT signals
   // -------------------------------------------------------------------------
   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata;   // [31:0] name_key, [63:32] anchor_key
   logic [REQ_TUSER_BITS-1:0] req_tuser;   // [1:0] kind
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;   // [2:0] status, [34:3] entry_key, [39:35] zero
   logic                      rsp_tlast;

   list_scoreboard sb;

   bit          steady;          // no idling on either side while set
   int          hold_requests;   // bumped to ask the receiver for a long hold-off
   logic [31:0] key_pool[8];     // small pool so keys repeat and match

   keyed_ordered_list_insert_remove_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog: only fires if the run hangs
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // Offer one request and hold it until taken. tvalid is left high on return;
   // the next call or a pause decides whether it drops.
   task automatic send_request(kind_type kind, logic [31:0] name, logic [31:0] anchor);
      if (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {anchor, name};
      do @(posedge clock); while (!req_tready);
      // transaction taken at this edge
      sb.apply_request(kind, name, anchor);
   endtask

   // sender pause: nothing offered until every owed result is back
   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // mostly pool keys so removes and anchors hit; sometimes a live key
   function automatic logic [31:0] pick_name_key();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) return key_pool[$urandom_range(7)];
      if (roll < 75) return sb.live_key();
      return $urandom;
   endfunction

   // -------------------------------------------------------------------------
   // Result side: random back-pressure, plus the long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : result_side
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata, rsp_tlast);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int          n;
      int          roll;
      int          i;
      kind_type    kind;
      logic [31:0] name;
      logic [31:0] anchor;

      sb            = new();
      steady        = 1'b0;
      hold_requests = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= KIND_APPEND;

      key_pool[0] = 32'h0000_0000;
      key_pool[1] = 32'hFFFF_FFFF;
      for (i = 2; i < 8; i++) key_pool[i] = $urandom;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: empty list cases, extremes, duplicates, head and tail
      send_request(KIND_DUMP,   32'h0,         32'h0);          // empty dump
      send_request(KIND_REMOVE, 32'h0,         32'hFFFF_FFFF);  // remove from empty
      send_request(KIND_INSERT, 32'h5,         32'h0);          // no anchor in empty
      send_request(KIND_APPEND, 32'h0000_0000, 32'hFFFF_FFFF);
      send_request(KIND_APPEND, 32'hFFFF_FFFF, 32'h0);
      send_request(KIND_APPEND, 32'h1234_5678, 32'h0);
      send_request(KIND_APPEND, 32'hFFFF_FFFF, 32'h0);          // duplicate
      send_request(KIND_INSERT, 32'hA5A5_A5A5, 32'hFFFF_FFFF);  // before first dup
      send_request(KIND_INSERT, 32'h5A5A_5A5A, 32'h0000_0000);  // new head
      send_request(KIND_INSERT, 32'h1111_1111, 32'hDEAD_BEEF);  // anchor absent
      send_request(KIND_DUMP,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);          // first of dups
      send_request(KIND_REMOVE, 32'hDEAD_BEEF, 32'h0);          // absent
      send_request(KIND_REMOVE, 32'h5A5A_5A5A, 32'h0);          // head
      send_request(KIND_DUMP,   32'h0,         32'h0);
      send_request(KIND_REMOVE, 32'hFFFF_FFFF, 32'h0);          // tail
      send_request(KIND_DUMP,   32'h0,         32'h0);

      // --- fill to capacity with the receiver held off: the core backs up
      wait_for_results();
      hold_requests++;
      while (sb.count < CAPACITY)
         send_request(KIND_APPEND, pick_name_key(), $urandom);
      send_request(KIND_APPEND, $urandom, $urandom);                 // full
      send_request(KIND_INSERT, $urandom, sb.live_key());            // anchor hit, full
      send_request(KIND_INSERT, $urandom, 32'hDEAD_BEEF);            // not found first
      send_request(KIND_DUMP,   $urandom, $urandom);                 // all entries
      while (sb.count > 40)
         send_request(KIND_REMOVE, sb.live_key(), $urandom);
      send_request(KIND_DUMP,   $urandom, $urandom);

      // --- random: mostly hitting keys, a quiet stretch in the middle
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 5 && n < 30);
         if (n == 30) wait_for_results();
         roll   = $urandom_range(99);
         anchor = $urandom;
         // lean on removes when the list gets long
         if (sb.count > 40 && roll < 30) roll = 60;
         if (roll < 30) begin
            kind = KIND_APPEND;
            name = pick_name_key();
         end else if (roll < 55) begin
            kind = KIND_INSERT;
            name = pick_name_key();
            if ($urandom_range(99) < 65) anchor = sb.live_key();
            else anchor = pick_name_key();
         end else if (roll < 85) begin
            kind = KIND_REMOVE;
            name = ($urandom_range(99) < 70) ? sb.live_key() : pick_name_key();
         end else begin
            kind = KIND_DUMP;
            name = $urandom;
         end
         send_request(kind, name, anchor);
      end
      steady = 1'b0;

      // --- wind down
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0 && sb.outstanding() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
